@@ rtl/sprs_pkg.sv @@
`timescale 1ns / 1ps
package sprs_pkg;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_TAKE   = 2'd2;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;

    localparam logic REG_THRU_ENABLE = 1'b0;

    typedef struct packed {
        logic       thru_valid;
        logic [7:0] thru_first;
        logic [7:0] thru_second;
        logic [7:0] thru_third;
        logic       message_ready;
        logic       capturing;
        logic [8:0] message_length;
        logic       overflow;
        logic [7:0] read_data;
    } t_result;

endpackage

@@ rtl/sprs_store.sv @@
`timescale 1ns / 1ps
module sprs_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/sprs_ctrl.sv @@
`timescale 1ns / 1ps
module sprs_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_thru_enable,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic [1:0]           i_req_cmd,
    input  logic [7:0]           i_req_first,
    input  logic [7:0]           i_req_second,
    input  logic [7:0]           i_req_third,
    input  logic [7:0]           i_req_index,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output sprs_pkg::t_result    o_res,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [7:0]           o_wr_data,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [7:0]           i_rd_data
);
    import sprs_pkg::*;

    logic          r_busy;
    logic [1:0]    r_step;
    logic [1:0]    r_cmd;
    logic [7:0]    r_first;
    logic [7:0]    r_second;
    logic [7:0]    r_third;
    logic [7:0]    r_index;
    logic          r_thru;
    logic          r_ovf;
    logic          r_cap;
    logic          r_ready;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    t_result       r_out;

    logic          n_ovf;
    logic          n_cap;
    logic          n_ready;
    logic [CW-1:0] n_count;
    logic          last;
    logic          finish;
    logic          advance;
    logic          accept;
    logic [7:0]    cur_byte;
    logic          room;
    logic          in_range;
    t_result       result;

    always_comb begin
        unique case (r_cmd)
            CMD_PACKET: last = (r_step == STEP_THIRD);
            CMD_READ:   last = (r_step == STEP_SECOND);
            default:    last = (r_step == STEP_FIRST);
        endcase
    end

    assign finish  = r_busy && last && (!r_out_valid || i_res_ready);
    assign advance = r_busy && (!last || finish);
    assign o_req_ready = !r_busy || finish;
    assign accept  = i_req_valid && o_req_ready;

    always_comb begin
        unique case (r_step)
            STEP_FIRST:  cur_byte = r_first;
            STEP_SECOND: cur_byte = r_second;
            default:     cur_byte = r_third;
        endcase
    end

    assign room     = (r_count < CW'(DEPTH));
    assign in_range = (32'(r_index) < DEPTH);

    always_comb begin
        n_ovf     = r_ovf;
        n_cap     = r_cap;
        n_ready   = r_ready;
        n_count   = r_count;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_count);
        o_wr_data = cur_byte;
        if (advance) begin
            unique case (r_cmd)
                CMD_PACKET: begin
                    if (r_cap) begin
                        if (room) begin
                            o_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (cur_byte == SYSEX_END) begin
                            n_cap   = 1'b0;
                            n_ready = 1'b1;
                        end
                    end else if (cur_byte == SYSEX_START) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = '0;
                        n_count   = CW'(1);
                        n_cap     = 1'b1;
                        n_ready   = 1'b0;
                    end
                end
                CMD_TAKE: n_ready = 1'b0;
                default: ;
            endcase
        end
    end

    assign o_rd_en   = advance && (r_cmd == CMD_READ) && (r_step == STEP_FIRST);
    assign o_rd_addr = AW'(r_index);

    always_comb begin
        result                = '0;
        result.message_ready  = n_ready;
        result.capturing      = n_cap;
        result.message_length = 9'(n_count);
        if (r_cmd == CMD_PACKET) begin
            result.overflow = n_ovf;
            if (r_thru) begin
                result.thru_valid  = 1'b1;
                result.thru_first  = r_first;
                result.thru_second = r_second;
                result.thru_third  = r_third;
            end
        end
        if (r_cmd == CMD_READ && in_range) begin
            result.read_data = i_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_FIRST;
            r_cap       <= 1'b0;
            r_ready     <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap   <= n_cap;
            r_ready <= n_ready;
            r_count <= n_count;
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= STEP_FIRST;
                r_ovf  <= 1'b0;
            end else begin
                r_ovf <= n_ovf;
                if (finish) begin
                    r_busy <= 1'b0;
                end else if (advance) begin
                    r_step <= r_step + 2'd1;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_req_cmd;
            r_first  <= i_req_first;
            r_second <= i_req_second;
            r_third  <= i_req_third;
            r_index  <= i_req_index;
            r_thru   <= i_thru_enable;
        end
        if (finish) begin
            r_out <= result;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    a_cap_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cap && r_ready))
        else $error("capture and ready both set");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond buffer");
    a_cap_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap |-> (r_count != '0))
        else $error("capturing with empty buffer");
    a_no_drop_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !last) |=> (r_busy && r_step == $past(r_step) + 2'd1))
        else $error("request left before its last step");
`endif

endmodule

@@ rtl/sysex_packet_reassembler_top.sv @@
`timescale 1ns / 1ps
// sysex reassembler: each request on the slave stream yields one result on the master
// stream. a packet request takes one buffer write slot per payload byte, set by the
// single write port of the message buffer; a read request issues the registered
// buffer read and then takes its data; a take or an unused code ends in its first
// step. the next request is taken in the cycle the current one moves to the output
// register; a result waiting downstream stalls the last step, blocking the next request.
// no clearing after reset: buffer contents valid only where written by a captured message.
module sysex_packet_reassembler_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // payload_first, payload_second, payload_third, read_index
    input  logic [31:0] i_s_tdata,
    // cmd
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // thru_first, thru_second, thru_third, message_ready, capturing,
    // message_length, overflow, read_data, zero fill
    output logic [47:0] o_m_tdata,
    // thru_valid
    output logic        o_m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sprs_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic          r_thru_enable;
    t_result       res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thru_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_THRU_ENABLE) begin
            r_thru_enable <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_THRU_ENABLE) ? {31'd0, r_thru_enable} : 32'd0;

    sprs_ctrl #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_thru_enable (r_thru_enable),
        .i_req_valid   (i_s_tvalid),
        .o_req_ready   (o_s_tready),
        .i_req_cmd     (i_s_tuser),
        .i_req_first   (i_s_tdata[7:0]),
        .i_req_second  (i_s_tdata[15:8]),
        .i_req_third   (i_s_tdata[23:16]),
        .i_req_index   (i_s_tdata[31:24]),
        .o_res_valid   (o_m_tvalid),
        .i_res_ready   (i_m_tready),
        .o_res         (res),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    sprs_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_m_tdata = {4'd0, res.read_data, res.overflow, res.message_length,
                        res.capturing, res.message_ready, res.thru_third,
                        res.thru_second, res.thru_first};
    assign o_m_tuser = res.thru_valid;

endmodule
